FILE: hdl/pidaw_pkg.sv
`default_nettype none

package pidaw_pkg;

  // Field and datapath widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned QUO_W  = DATA_W + FRAC_W;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned CNT_W  = $clog2(QUO_W + 1);

  // Q16.16 constants held at 34 bits so wrapped errors compare without overflow
  localparam logic signed [33:0] Q_PI         = 34'sd205887;
  localparam logic signed [33:0] Q_TWO_PI     = 34'sd411775;
  localparam logic signed [33:0] Q_TARGET_EPS = 34'sd66;

  // Configuration register indexes
  localparam logic [1:0] CFG_ANGLE_MODE = 2'd0;
  localparam logic [1:0] CFG_GAIN_P     = 2'd1;
  localparam logic [1:0] CFG_GAIN_I     = 2'd2;
  localparam logic [1:0] CFG_GAIN_D     = 2'd3;

  // One input transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic        [DATA_W-1:0] time_step;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;
    logic                     zero_step;
  } out_item_t;

  // Operands of the shared multiplier
  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // Divider request and status
  typedef struct packed {
    logic                     start;
    logic signed [DATA_W:0]   num;
    logic        [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP_T,
    ST_TARGET,
    ST_ERR,
    ST_ERR_WRAP,
    ST_DIFF,
    ST_MUL_GP,
    ST_CLAMP_SUM,
    ST_MUL_GIH,
    ST_MUL_GIL,
    ST_ACC_GIL,
    ST_DIV_WAIT,
    ST_MUL_GD,
    ST_ACC_GD,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/pidaw_mul.sv
`default_nettype none

module pidaw_mul
  import pidaw_pkg::*;
(
  input  wire logic                     clk,
  input  wire mul_req_t                 req,
  output logic signed [PROD_W-1:0]      prod
);

  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod_r;

  assign op_a = req.a;
  assign op_b = req.b;

  // Signed multiply with the full product registered
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: hdl/pidaw_div.sv
`default_nettype none

module pidaw_div
  import pidaw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam logic [CNT_W-1:0] STEPS = CNT_W'(QUO_W);

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DATA_W-1:0]   rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [DATA_W-1:0]   den_r;
  logic signed [DATA_W:0] num_abs;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W+1:0]   trial;
  logic                fits;

  // Magnitude of the signed difference; it always fits in DATA_W bits
  assign num_abs = req.num[DATA_W] ? -req.num : req.num;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_r, quo_r[QUO_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};
  assign fits   = ~trial[DATA_W+1];

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEPS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register; the dividend carries FRAC_W zero bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= {num_abs[DATA_W-1:0], {FRAC_W{1'b0}}};
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

FILE: hdl/pid_controller_angle_wrap.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_item_t  (setpoint, measured, time_step)
// out_      output     out_valid / out_stall  out_item_t (drive, saturated, zero_step)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A new item is accepted only once the sequencer is back in idle. When time_step is
// nonzero, the 48-step restoring divider for the derivative sets the pace, and the
// multiplies run on one shared 33x33 multiplier while it works. A zero time_step
// skips the divide. Reset (rst_n low, synchronous) clears the gains, angle mode and
// controller state. A finished result waits in the output register under out_stall
// while the next item is accepted; a second finished result then holds the
// sequencer in its final step. cfg_ready is always high.

module pid_controller_angle_wrap
  import pidaw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [DATA_W-1:0]  cfg_data
);

  localparam logic signed [33:0] E_MAX   = 34'sd2147483647;
  localparam logic signed [33:0] E_MIN   = -34'sd2147483648;
  localparam logic signed [48:0] SUM_MAX = 49'sd140737488355327;
  localparam logic signed [48:0] SUM_MIN = -49'sd140737488355328;
  localparam logic signed [ACC_W-1:0] DRV_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] DRV_MIN = -64'sd2147483648;
  localparam logic [QUO_W-1:0] QUO_POS_MAX = 48'd2147483647;
  localparam logic [QUO_W-1:0] QUO_NEG_MAX = 48'd2147483648;

  // Configuration registers
  logic                     angle_mode_r;
  logic signed [DATA_W-1:0] gain_p_r;
  logic signed [DATA_W-1:0] gain_i_r;
  logic signed [DATA_W-1:0] gain_d_r;

  // Sequencer and controller state
  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] held_target_r, held_target_nxt;
  logic signed [DATA_W-1:0] last_error_r, last_error_nxt;
  logic signed [SUM_W-1:0]  error_sum_r, error_sum_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Per-item working registers
  logic signed [DATA_W-1:0] tgt_r, tgt_nxt;
  logic signed [DATA_W-1:0] meas_r, meas_nxt;
  logic        [DATA_W-1:0] dt_r, dt_nxt;
  logic signed [DATA_W:0]   err_raw_r, err_raw_nxt;
  logic signed [DATA_W-1:0] err_r, err_nxt;
  logic signed [DATA_W:0]   dd_r, dd_nxt;
  logic signed [48:0]       sum49_r, sum49_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DATA_W-1:0] deriv_r, deriv_nxt;
  logic                     sat_r, sat_nxt;
  logic                     zero_r, zero_nxt;
  out_item_t                out_data_r, out_data_nxt;

  // Shared units
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Helper values
  logic signed [33:0]       tgt_ext;
  logic signed [33:0]       tgt_wrap;
  logic signed [33:0]       tdiff;
  logic signed [33:0]       e_ext;
  logic signed [33:0]       e_wrap;
  logic                     e_wrapped;
  logic signed [ACC_W-1:0]  prod_q;

  pidaw_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  pidaw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_mode_r <= 1'b0;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANGLE_MODE: angle_mode_r <= cfg_data[0];
        CFG_GAIN_P:     gain_p_r     <= cfg_data;
        CFG_GAIN_I:     gain_i_r     <= cfg_data;
        CFG_GAIN_D:     gain_d_r     <= cfg_data;
        default:        angle_mode_r <= angle_mode_r;
      endcase
    end
  end

  // Target wrap and change detection
  always_comb begin
    tgt_ext = 34'(tgt_r);
    if (angle_mode_r && (tgt_ext < -Q_PI)) begin
      tgt_wrap = tgt_ext + Q_TWO_PI;
    end else if (angle_mode_r && (tgt_ext > Q_PI)) begin
      tgt_wrap = tgt_ext - Q_TWO_PI;
    end else begin
      tgt_wrap = tgt_ext;
    end
    tdiff = tgt_ext - 34'(held_target_r);
  end

  // Error wrap
  always_comb begin
    e_ext = 34'(err_raw_r);
    if (angle_mode_r && (e_ext < -Q_PI)) begin
      e_wrap    = e_ext + Q_TWO_PI;
      e_wrapped = 1'b1;
    end else if (angle_mode_r && (e_ext > Q_PI)) begin
      e_wrap    = e_ext - Q_TWO_PI;
      e_wrapped = 1'b1;
    end else begin
      e_wrap    = e_ext;
      e_wrapped = 1'b0;
    end
  end

  // Product floored by 2^16, sign extended to the accumulator width
  assign prod_q = ACC_W'($signed(prod[PROD_W-1:FRAC_W]));

  // Sequencer: next state, state updates and shared-unit operands
  always_comb begin
    state_nxt       = state_r;
    held_target_nxt = held_target_r;
    last_error_nxt  = last_error_r;
    error_sum_nxt   = error_sum_r;
    out_valid_nxt   = out_valid_r;
    tgt_nxt         = tgt_r;
    meas_nxt        = meas_r;
    dt_nxt          = dt_r;
    err_raw_nxt     = err_raw_r;
    err_nxt         = err_r;
    dd_nxt          = dd_r;
    sum49_nxt       = sum49_r;
    acc_nxt         = acc_r;
    deriv_nxt       = deriv_r;
    sat_nxt         = sat_r;
    zero_nxt        = zero_r;
    out_data_nxt    = out_data_r;
    mul_req.a       = '0;
    mul_req.b       = '0;
    div_req.start   = 1'b0;
    div_req.num     = dd_r;
    div_req.den     = dt_r;

    // The consumer takes the waiting result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tgt_nxt   = in_data.setpoint;
          meas_nxt  = in_data.measured;
          dt_nxt    = in_data.time_step;
          zero_nxt  = (in_data.time_step == '0);
          sat_nxt   = 1'b0;
          state_nxt = ST_WRAP_T;
        end
      end
      ST_WRAP_T: begin
        tgt_nxt   = tgt_wrap[DATA_W-1:0];
        state_nxt = ST_TARGET;
      end
      ST_TARGET: begin
        // A new target restarts the integral and derivative history
        if ((tdiff > Q_TARGET_EPS) || (tdiff < -Q_TARGET_EPS)) begin
          held_target_nxt = tgt_r;
          last_error_nxt  = '0;
          error_sum_nxt   = '0;
        end
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        err_raw_nxt = 33'(held_target_r) - 33'(meas_r);
        state_nxt   = ST_ERR_WRAP;
      end
      ST_ERR_WRAP: begin
        if (e_wrapped) begin
          last_error_nxt = '0;
          error_sum_nxt  = '0;
        end
        if (e_wrap > E_MAX) begin
          err_nxt = E_MAX[DATA_W-1:0];
        end else if (e_wrap < E_MIN) begin
          err_nxt = E_MIN[DATA_W-1:0];
        end else begin
          err_nxt = e_wrap[DATA_W-1:0];
        end
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        dd_nxt         = 33'(err_r) - 33'(last_error_r);
        last_error_nxt = err_r;
        mul_req.a      = 33'(err_r);
        mul_req.b      = $signed({1'b0, dt_r});
        state_nxt      = ST_MUL_GP;
      end
      ST_MUL_GP: begin
        // Product holds error * time_step
        div_req.start = ~zero_r;
        sum49_nxt     = 49'(error_sum_r) + $signed(prod[64:FRAC_W]);
        mul_req.a     = 33'(gain_p_r);
        mul_req.b     = 33'(err_r);
        state_nxt     = ST_CLAMP_SUM;
      end
      ST_CLAMP_SUM: begin
        // Product holds gain_p * error
        acc_nxt = prod_q;
        if (sum49_r > SUM_MAX) begin
          error_sum_nxt = SUM_MAX[SUM_W-1:0];
          sat_nxt       = 1'b1;
        end else if (sum49_r < SUM_MIN) begin
          error_sum_nxt = SUM_MIN[SUM_W-1:0];
          sat_nxt       = 1'b1;
        end else begin
          error_sum_nxt = sum49_r[SUM_W-1:0];
        end
        state_nxt = ST_MUL_GIH;
      end
      ST_MUL_GIH: begin
        mul_req.a = 33'(gain_i_r);
        mul_req.b = 33'($signed(error_sum_r[SUM_W-1:FRAC_W]));
        state_nxt = ST_MUL_GIL;
      end
      ST_MUL_GIL: begin
        // Upper integral word carries its 2^16 weight, so it adds unshifted
        acc_nxt   = acc_r + $signed(prod[ACC_W-1:0]);
        mul_req.a = 33'(gain_i_r);
        mul_req.b = $signed({{(MUL_W-FRAC_W){1'b0}}, error_sum_r[FRAC_W-1:0]});
        state_nxt = ST_ACC_GIL;
      end
      ST_ACC_GIL: begin
        acc_nxt   = acc_r + prod_q;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        // Apply the sign to the quotient magnitude and clip to 32 bits
        if (zero_r) begin
          deriv_nxt = '0;
          state_nxt = ST_MUL_GD;
        end else if (!div_rsp.busy) begin
          if (dd_r[DATA_W]) begin
            if (div_rsp.quo > QUO_NEG_MAX) begin
              deriv_nxt = E_MIN[DATA_W-1:0];
            end else begin
              deriv_nxt = -$signed(div_rsp.quo[DATA_W-1:0]);
            end
          end else begin
            if (div_rsp.quo > QUO_POS_MAX) begin
              deriv_nxt = E_MAX[DATA_W-1:0];
            end else begin
              deriv_nxt = $signed(div_rsp.quo[DATA_W-1:0]);
            end
          end
          state_nxt = ST_MUL_GD;
        end
      end
      ST_MUL_GD: begin
        mul_req.a = 33'(gain_d_r);
        mul_req.b = 33'(deriv_r);
        state_nxt = ST_ACC_GD;
      end
      ST_ACC_GD: begin
        acc_nxt   = acc_r + prod_q;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.zero_step = zero_r;
          if (acc_r > DRV_MAX) begin
            out_data_nxt.drive     = DRV_MAX[DATA_W-1:0];
            out_data_nxt.saturated = 1'b1;
          end else if (acc_r < DRV_MIN) begin
            out_data_nxt.drive     = DRV_MIN[DATA_W-1:0];
            out_data_nxt.saturated = 1'b1;
          end else begin
            out_data_nxt.drive     = acc_r[DATA_W-1:0];
            out_data_nxt.saturated = sat_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      held_target_r <= '0;
      last_error_r  <= '0;
      error_sum_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      held_target_r <= held_target_nxt;
      last_error_r  <= last_error_nxt;
      error_sum_r   <= error_sum_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    meas_r     <= meas_nxt;
    dt_r       <= dt_nxt;
    err_raw_r  <= err_raw_nxt;
    err_r      <= err_nxt;
    dd_r       <= dd_nxt;
    sum49_r    <= sum49_nxt;
    acc_r      <= acc_nxt;
    deriv_r    <= deriv_nxt;
    sat_r      <= sat_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider has always finished by the time the sequencer returns to idle
  a_div_done_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_rsp.busy)
    else $error("divider still busy while idle");

  // A finished result is not dropped while the previous one is still held
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid_r && out_stall |=> state_r == ST_DONE)
    else $error("result left while output register was occupied");

  // A new result only appears after the final sequencer step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("output valid raised outside the final step");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pidaw_pkg::*;

  localparam int          S32_MAX     = 32'sh7FFF_FFFF;
  localparam int          S32_MIN     = 32'sh8000_0000;
  localparam int unsigned U32_MAX     = 32'hFFFF_FFFF;
  localparam int          ONE_Q16     = 65536;
  localparam int          HOLD_CYCLES = 600;

  // Fixed-point constants of the control law, Q16.16.
  localparam longint PI_Q16     = 205887;
  localparam longint TWO_PI_Q16 = 411775;
  localparam longint TARGET_EPS = 66;
  localparam longint SUM_HI     = (longint'(1) <<< 47) - 1;
  localparam longint SUM_LO     = -(longint'(1) <<< 47);

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Controller settings and loop state as the predictor sees them.
  bit     ctl_angle;
  longint ctl_kp, ctl_ki, ctl_kd;
  longint st_target, st_prev_err, st_integral;

  out_item_t pid_results_due[$];

  int  items_sent;
  int  results_checked;
  int  cfg_writes;
  int  mismatches;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  hold_request;
  int  track_target;
  bit  track_set;

  pid_controller_angle_wrap u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Exact floor(gain * operand / 2^16), carried out at a width that cannot overflow.
  function automatic longint gain_term(longint gain, longint operand);
    logic signed [127:0] wide_gain;
    logic signed [127:0] wide_op;
    logic signed [127:0] prod;
    wide_gain = gain;
    wide_op   = operand;
    prod      = wide_gain * wide_op;
    prod      = prod >>> 16;
    return longint'(prod[63:0]);
  endfunction

  // One step of the angle-wrapping PID law; updates the loop state.
  function automatic out_item_t compute_pid_result(in_item_t it);
    longint    sp, meas, dt, err, gap, rate, acc, total;
    bit        sat, zero;
    out_item_t res;
    sp   = $signed(it.setpoint);
    meas = $signed(it.measured);
    dt   = {32'd0, it.time_step};
    sat  = 1'b0;
    zero = (dt == 0);

    // Target wrap happens once, then the new target is latched if it moved enough.
    if (ctl_angle) begin
      if (sp < -PI_Q16) sp += TWO_PI_Q16;
      else if (sp > PI_Q16) sp -= TWO_PI_Q16;
    end
    gap = sp - st_target;
    if (gap < 0) gap = -gap;
    if (gap > TARGET_EPS) begin
      st_target   = sp;
      st_prev_err = 0;
      st_integral = 0;
    end

    // A wrapped error restarts the integral and derivative history.
    err = st_target - meas;
    if (ctl_angle) begin
      if (err < -PI_Q16) begin
        err += TWO_PI_Q16;
        st_prev_err = 0;
        st_integral = 0;
      end else if (err > PI_Q16) begin
        err -= TWO_PI_Q16;
        st_prev_err = 0;
        st_integral = 0;
      end
    end
    err = clip(err, S32_MIN, S32_MAX);

    acc = st_integral + ((err * dt) >>> 16);
    if (acc > SUM_HI || acc < SUM_LO) begin
      sat = 1'b1;
      acc = clip(acc, SUM_LO, SUM_HI);
    end
    st_integral = acc;

    if (zero) rate = 0;
    else rate = clip(((err - st_prev_err) * 65536) / dt, S32_MIN, S32_MAX);
    st_prev_err = err;

    total = gain_term(ctl_kp, err) + gain_term(ctl_ki, st_integral)
          + gain_term(ctl_kd, rate);
    if (total > S32_MAX || total < S32_MIN) begin
      sat   = 1'b1;
      total = clip(total, S32_MIN, S32_MAX);
    end

    res.drive     = total[31:0];
    res.saturated = sat;
    res.zero_step = zero;
    return res;
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_gain();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_signed(1 << 18);
    if (r == 6) return S32_MAX;
    if (r == 7) return S32_MIN;
    return $urandom;
  endfunction

  function automatic in_item_t pack_item(int sp, int meas, int unsigned dt);
    in_item_t it;
    it.setpoint  = sp;
    it.measured  = meas;
    it.time_step = dt;
    return it;
  endfunction

  // Mostly a held target with small jitter and a nearby measurement; some pure noise.
  function automatic in_item_t make_item();
    in_item_t it;
    int       base;
    if ($urandom_range(0, 99) < 15) begin
      it.setpoint  = $urandom;
      it.measured  = $urandom;
      it.time_step = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      return it;
    end
    if (!track_set || $urandom_range(0, 19) == 0) begin
      track_target = ctl_angle ? rand_signed(300000) : rand_signed(1 << 22);
      track_set    = 1'b1;
    end
    case ($urandom_range(0, 9))
      0: begin
        base = track_target + (($urandom_range(0, 1) != 0) ? 66 : -66);
      end
      1: begin
        base = track_target + (($urandom_range(0, 1) != 0) ? 67 : -67);
      end
      default: begin
        base = track_target + rand_signed(30);
      end
    endcase
    it.setpoint = base;
    if (ctl_angle && $urandom_range(0, 7) == 0)
      it.measured = track_target + rand_signed(2 * 205887);
    else
      it.measured = track_target + rand_signed(1 << 17);
    case ($urandom_range(0, 19))
      0, 1: begin
        it.time_step = 32'd0;
      end
      2: begin
        it.time_step = $urandom;
      end
      3: begin
        it.time_step = $urandom_range(1, 16);
      end
      default: begin
        it.time_step = $urandom_range(1, 1 << 16);
      end
    endcase
    return it;
  endfunction

  function automatic void report_mismatch(string what, longint want, longint got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  // Offer one transaction and hold it until accepted; valid stays high afterwards.
  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pid_results_due.push_back(compute_pid_result(it));
    items_sent++;
  endtask

  task automatic sender_pause();
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pid_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ANGLE_MODE: ctl_angle = value[0];
      CFG_GAIN_P:     ctl_kp = $signed(value);
      CFG_GAIN_I:     ctl_ki = $signed(value);
      CFG_GAIN_D:     ctl_kd = $signed(value);
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the block has delivered everything outstanding.
  task automatic set_controller(bit angle, int kp, int ki, int kd);
    wait_results_drained();
    write_reg(CFG_ANGLE_MODE, {31'd0, angle});
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    track_set = 1'b0;
  endtask

  // With all gains at their reset value of zero the drive must stay zero.
  task automatic test_reset_state();
    send_item(pack_item(0, 0, 0));
    send_item(pack_item(S32_MAX, S32_MIN, U32_MAX));
  endtask

  // Target hysteresis, zero time step, error and integral clipping, derivative clip.
  task automatic test_gain_terms();
    set_controller(1'b0, ONE_Q16, ONE_Q16 / 2, ONE_Q16 / 4);
    send_item(pack_item(1000, 0, ONE_Q16));
    send_item(pack_item(1066, 500, ONE_Q16));
    send_item(pack_item(1067, 0, 0));
    send_item(pack_item(S32_MAX, S32_MIN, U32_MAX));
    send_item(pack_item(S32_MAX, S32_MIN, U32_MAX));
    send_item(pack_item(S32_MIN, S32_MAX, 1));
    send_item(pack_item(S32_MIN, S32_MIN, U32_MAX));
  endtask

  task automatic test_gain_extremes();
    set_controller(1'b0, S32_MAX, S32_MIN, S32_MAX);
    send_item(pack_item(12345, -99999, 3));
    send_item(pack_item(12345, 99999, 0));
    set_controller(1'b0, S32_MIN, S32_MAX, S32_MIN);
    send_item(pack_item(-7, 7, ONE_Q16));
    send_item(pack_item(S32_MAX, S32_MIN, ONE_Q16));
  endtask

  // Wraps just past pi on both sides, exactly at pi, and far outside the range.
  task automatic test_angle_wrap();
    set_controller(1'b1, ONE_Q16, ONE_Q16, ONE_Q16);
    send_item(pack_item(205888, 0, ONE_Q16));
    send_item(pack_item(-205888, 0, ONE_Q16));
    send_item(pack_item(205887, -205887, ONE_Q16));
    send_item(pack_item(-205887, 205887, ONE_Q16));
    send_item(pack_item(S32_MAX, S32_MIN, U32_MAX));
    send_item(pack_item(100000, 100000, ONE_Q16));
    send_item(pack_item(100000, 0, 0));
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_controller(1'b0, rand_signed(1 << 18), rand_signed(1 << 16),
                          rand_signed(1 << 16));
        1: set_controller(1'b1, rand_signed(1 << 18), rand_signed(1 << 16),
                          rand_signed(1 << 16));
        2: set_controller(1'b0, S32_MAX, S32_MAX, S32_MAX);
        3: set_controller(1'b1, S32_MIN, S32_MIN, S32_MIN);
        4: set_controller($urandom_range(0, 1), 0, 0, 0);
        default: set_controller($urandom_range(0, 1), pick_gain(), pick_gain(), pick_gain());
      endcase
      for (int k = 0; k < 130; k++) begin
        send_item(make_item());
        sender_pause();
      end
    end
  endtask

  // The receiver holds off for a long stretch while transactions keep coming.
  task automatic test_output_backpressure();
    set_controller(1'b1, rand_signed(1 << 18), rand_signed(1 << 16), rand_signed(1 << 16));
    hold_request = 1'b1;
    for (int k = 0; k < 12; k++) send_item(make_item());
    while (hold_request) begin
      send_item(make_item());
    end
    wait_results_drained();
  endtask

  // The sender stops until every outstanding result has been delivered.
  task automatic test_sender_pause();
    set_controller(1'b0, rand_signed(1 << 18), rand_signed(1 << 16), rand_signed(1 << 16));
    for (int g = 0; g < 6; g++) begin
      for (int k = 0; k < 5; k++) begin
        send_item(make_item());
        sender_pause();
      end
      wait_results_drained();
    end
  endtask

  // Final stretch with no idling on either side.
  task automatic test_full_rate();
    set_controller($urandom_range(0, 1), pick_gain(), pick_gain(), pick_gain());
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int k = 0; k < 200; k++) send_item(make_item());
  endtask

  // Receiver stall pattern: random bursts, quiet stretches and one long hold.
  initial begin : receiver_stall
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Compare every delivered transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pid_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no prediction waiting, actual drive %0d", $time,
                 out_data.drive);
      end else begin
        want = pid_results_due.pop_front();
        results_checked++;
        if (out_data.drive !== want.drive)
          report_mismatch("drive", want.drive, out_data.drive);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", want.saturated, out_data.saturated);
        if (out_data.zero_step !== want.zero_step)
          report_mismatch("zero_step", want.zero_step, out_data.zero_step);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : run_tests
    int guard;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_ANGLE_MODE;
    cfg_data    = '0;
    ctl_angle   = 1'b0;
    ctl_kp      = 0;
    ctl_ki      = 0;
    ctl_kd      = 0;
    st_target   = 0;
    st_prev_err = 0;
    st_integral = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    hold_request = 1'b0;
    track_set   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_state();
    test_gain_terms();
    test_gain_extremes();
    test_angle_wrap();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();

    // Let the last results come out, then watch for strays.
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pid_results_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (pid_results_due.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, pid_results_due.size());
      mismatches += pid_results_due.size();
    end

    $display("Ran %0d transactions in, checked %0d results, made %0d register writes.",
             items_sent, results_checked, cfg_writes);
    $display("Exercised angle wrap, target hysteresis, clipping, zero steps and a long hold.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: pid_controller_angle_wrap.f
hdl/pidaw_pkg.sv
hdl/pidaw_mul.sv
hdl/pidaw_div.sv
hdl/pid_controller_angle_wrap.sv
sim/tb_top.sv
